@@ src/ata_pkg.sv @@
// ----------------------------------------------------------------------------
// ata_pkg
// Shared types and constants for the ATA PIO LBA28 host sequencer.
// ----------------------------------------------------------------------------
package ata_pkg;

  localparam int SECTOR_WORDS = 256;
  localparam int MODEL_WORDS  = 20;
  localparam int MODEL_FIRST  = 27;
  localparam int SECT_LO_WORD = 60;
  localparam int SECT_HI_WORD = 61;
  localparam logic [19:0] POLL_BUDGET_RESET = 20'd1000000;

  typedef enum logic [2:0] {
    F_IDENTIFY = 3'd0, F_READ = 3'd1, F_WRITE = 3'd2, F_REPLY = 3'd3, F_WORD = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    K_BUS_WR = 3'd0, K_BUS_RD = 3'd1, K_SECTOR = 3'd2, K_NEED_WR = 3'd3,
    K_MODEL = 3'd4, K_DONE = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_ABSENT = 3'd1, ST_RANGE = 3'd2, ST_DEVERR = 3'd3,
    ST_TIMEOUT = 3'd4, ST_NODEV = 3'd5, ST_NOTATA = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ID_SETTLE, PH_ID_FIRST, PH_ID_NB, PH_ID_MID, PH_ID_HI,
    PH_ID_DRQ, PH_ID_DATA, PH_RW_NB, PH_RW_SETTLE, PH_RW_DRQ, PH_RD_DATA,
    PH_RD_SETTLE, PH_WR_DATA, PH_WR_FLUSH,
    // emission sequencing phases
    PH_SEQ, PH_MODEL_SCAN, PH_MODEL_OUT
  } phase_t;

  // one result transaction
  typedef struct packed {
    logic [2:0]  kind;
    logic        control_block;
    logic [2:0]  reg_offset;
    logic        wide;
    logic [15:0] word;
    logic [2:0]  status;
    logic [31:0] sector_count;
    logic        last;
  } result_t;

  // controller -> datapath commands
  typedef struct packed {
    logic        clear_id;      // identify start
    logic        latch_req;     // take lba / op
    logic        op_write;
    logic        clr_poll;
    logic        inc_poll;
    logic        clr_settle;
    logic        inc_settle;
    logic        clr_index;
    logic        inc_index;
    logic        store_word;    // identify data word capture
    logic        scan_start;
    logic        scan_step;
    logic        out_clr;
    logic        out_step;
    logic        set_present;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic        present;
    logic        range_bad;
    logic        poll_exhausted;   // poll_count+1 >= budget
    logic        budget_zero;
    logic        settle_done;      // settle_count >= 3
    logic        index_last;       // word_index == SECTOR_WORDS-1
    logic        scan_busy_space;  // current scanned byte is space
    logic        scan_done;
    logic        out_last;
  } dp_stat_t;

endpackage

@@ src/ata_datapath.sv @@
// ----------------------------------------------------------------------------
// ata_datapath
// Counters, latched request, sector total and model store with trim scan.
// ----------------------------------------------------------------------------
module ata_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  ata_pkg::dp_cmd_t     cmd,
  input  logic [47:0]          lba,
  input  logic [15:0]          data,
  input  logic [19:0]          poll_budget,
  output ata_pkg::dp_stat_t    stat,
  output logic [27:0]          latched_lba,
  output logic                 op_is_write,
  output logic [31:0]          total_sectors,
  output logic [15:0]          model_word
);
  import ata_pkg::*;

  logic        drive_present;
  logic [19:0] poll_count;
  logic [1:0]  settle_count;
  logic [8:0]  word_index;
  logic [15:0] model_store [MODEL_WORDS];
  logic [5:0]  trim_len;     // bytes kept (0..40)
  logic [5:0]  scan_pos;     // byte under test, counts down
  logic [4:0]  out_idx;
  logic [15:0] scan_word;
  logic [7:0]  scan_byte;
  logic [4:0]  store_idx;
  logic [4:0]  oi1, oi0;

  // hold control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_present <= 1'b0;
      total_sectors <= '0;
      poll_count    <= '0;
      settle_count  <= '0;
      word_index    <= '0;
      op_is_write   <= 1'b0;
      latched_lba   <= '0;
      scan_pos      <= '0;
      trim_len      <= '0;
      out_idx       <= '0;
    end else begin
      if (cmd.clear_id) begin
        drive_present <= 1'b0;
        total_sectors <= '0;
      end
      if (cmd.set_present) drive_present <= 1'b1;
      if (cmd.latch_req) begin
        latched_lba <= lba[27:0];
        op_is_write <= cmd.op_write;
      end
      if (cmd.clr_poll) poll_count <= '0;
      else if (cmd.inc_poll) poll_count <= poll_count + 20'd1;
      if (cmd.clr_settle) settle_count <= '0;
      else if (cmd.inc_settle) settle_count <= settle_count + 2'd1;
      if (cmd.clr_index) word_index <= '0;
      else if (cmd.inc_index) word_index <= word_index + 9'd1;
      if (cmd.store_word) begin
        if (word_index == 9'(SECT_LO_WORD)) total_sectors[15:0]  <= data;
        if (word_index == 9'(SECT_HI_WORD)) total_sectors[31:16] <= data;
      end
      // trim scan walks down from the last byte
      if (cmd.scan_start) begin
        scan_pos <= 6'(2 * MODEL_WORDS - 1);
        trim_len <= 6'(2 * MODEL_WORDS);
      end else if (cmd.scan_step) begin
        trim_len <= trim_len - 6'd1;
        scan_pos <= scan_pos - 6'd1;
      end
      if (cmd.out_clr) out_idx <= '0;
      else if (cmd.out_step) out_idx <= out_idx + 5'd1;
    end
  end

  // write model words
  assign store_idx = 5'(word_index - 9'(MODEL_FIRST));
  always_ff @(posedge clk) begin
    if (cmd.store_word && word_index >= 9'(MODEL_FIRST) &&
        word_index < 9'(MODEL_FIRST + MODEL_WORDS))
      model_store[store_idx] <= data;
  end

  // read for scan and output
  assign scan_word = model_store[5'(scan_pos >> 1)];
  assign scan_byte = scan_pos[0] ? scan_word[7:0] : scan_word[15:8];
  always_comb begin
    logic [15:0] w;
    w  = model_store[out_idx];
    oi1 = out_idx;
    oi0 = out_idx;
    model_word = w;
    if ({oi1, 1'b0} >= trim_len) model_word[15:8] = 8'h00;
    if ({oi0, 1'b1} >= trim_len) model_word[7:0]  = 8'h00;
  end

  always_comb begin
    stat.present         = drive_present;
    stat.range_bad       = (lba >= {16'd0, total_sectors}) || (lba[47:28] != '0);
    stat.poll_exhausted  = (poll_count + 20'd1) >= poll_budget;
    stat.budget_zero     = (poll_budget == '0);
    stat.settle_done     = (settle_count == 2'd3);
    stat.index_last      = (word_index == 9'(SECTOR_WORDS - 1));
    stat.scan_busy_space = (scan_byte == 8'h20);
    stat.scan_done       = (trim_len == '0);
    stat.out_last        = (out_idx == 5'(MODEL_WORDS - 1));
  end
endmodule

@@ src/ata_ctrl.sv @@
// ----------------------------------------------------------------------------
// ata_ctrl
// Protocol state machine: decodes input transactions and emits results, one
// per cycle unless stalled or trimming, from a short queue of pending accesses.
// ----------------------------------------------------------------------------
module ata_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           func,
  input  logic [15:0]          data,
  input  ata_pkg::dp_stat_t    stat,
  input  logic [27:0]          latched_lba,
  input  logic                 op_is_write,
  input  logic [31:0]          total_sectors,
  input  logic [15:0]          model_word,
  output ata_pkg::dp_cmd_t     cmd,
  output logic                 res_valid,
  input  logic                 res_stall,
  output ata_pkg::result_t     res
);
  import ata_pkg::*;

  // A pending sequence is a list of up to 7 results, each from a small code
  typedef enum logic [3:0] {
    E_WR_DEVSEL, E_WR_ZERO2, E_WR_ZERO3, E_WR_ZERO4, E_WR_ZERO5, E_WR_IDCMD,
    E_RD_STATUS, E_RD_ALT, E_RD_MID, E_RD_HI, E_RD_DATA,
    E_WR_CNT, E_WR_L0, E_WR_L1, E_WR_L2, E_WR_RWCMD
  } ecode_t;

  typedef enum logic [1:0] { T_NONE, T_EXTRA_DONE, T_NEED_WR, T_MODEL } tail_t;

  phase_t      phase, phase_next;      // protocol phase after the sequence
  phase_t      run;                    // PH_IDLE or emitting
  ecode_t      seq [7];
  logic [2:0]  seq_len, seq_pos;
  tail_t       tail;
  status_t     done_st;
  logic        done_flag;              // sequence ends in done
  logic        flush_pending;          // write word emitted first
  logic        pass_word_valid;
  logic [15:0] pass_word;
  logic        pass_sector;

  // next-sequence decision
  ecode_t      nseq [7];
  logic [2:0]  nlen;
  logic        ndone;
  status_t     nst;
  tail_t       ntail;
  logic        npass, npass_sector, nfire;
  logic [7:0]  b;
  logic        accept;
  logic        pok, pfail_dev, pfail_to, pstill;

  assign b = data[7:0];
  assign in_stall = (run != PH_IDLE);
  assign accept = in_valid && !in_stall;

  // poll resolution for current reply
  always_comb begin
    logic drq;
    drq = (phase == PH_ID_DRQ) || (phase == PH_RW_DRQ);
    pok = 1'b0; pfail_dev = 1'b0;
    if (drq) begin
      if ((b & 8'h21) != 0) pfail_dev = 1'b1;
      else if (!b[7] && b[3]) pok = 1'b1;
    end else if (!b[7]) begin
      if ((b & 8'h21) != 0) pfail_dev = 1'b1;
      else pok = 1'b1;
    end
    pfail_to = !pok && !pfail_dev && stat.poll_exhausted;
    pstill   = !pok && !pfail_dev && !stat.poll_exhausted;
  end

  // next state and command decode
  always_comb begin
    phase_next = phase;
    cmd = '0;
    for (int i = 0; i < 7; i++) nseq[i] = E_RD_STATUS;
    nlen = '0; ndone = 1'b0; nst = ST_OK; ntail = T_NONE;
    npass = 1'b0; npass_sector = 1'b0; nfire = 1'b0;
    if (accept) begin
      nfire = 1'b1;
      if (phase == PH_IDLE) begin
        unique case (func)
          F_IDENTIFY: begin
            cmd.clear_id = 1'b1; cmd.clr_settle = 1'b1;
            nseq[0] = E_WR_DEVSEL; nseq[1] = E_RD_ALT; nlen = 3'd2;
            phase_next = PH_ID_SETTLE;
          end
          F_READ, F_WRITE: begin
            if (!stat.present) begin ndone = 1'b1; nst = ST_ABSENT; end
            else if (stat.range_bad) begin ndone = 1'b1; nst = ST_RANGE; end
            else begin
              cmd.latch_req = 1'b1; cmd.op_write = (func == F_WRITE);
              cmd.clr_poll = 1'b1;
              if (stat.budget_zero) begin ndone = 1'b1; nst = ST_TIMEOUT; end
              else begin nseq[0] = E_RD_STATUS; nlen = 3'd1; phase_next = PH_RW_NB; end
            end
          end
          default: nfire = 1'b0;
        endcase
      end else if (phase == PH_WR_DATA) begin
        if (func == F_WORD) begin
          npass = 1'b1; cmd.inc_index = 1'b1;
          if (stat.index_last) begin
            cmd.clr_poll = 1'b1;
            nseq[0] = E_WR_RWCMD; // flush command, word chosen below
            if (stat.budget_zero) begin nlen = 3'd1; ndone = 1'b1; nst = ST_TIMEOUT; end
            else begin nseq[1] = E_RD_STATUS; nlen = 3'd2; phase_next = PH_WR_FLUSH; end
          end
        end else nfire = 1'b0;
      end else if (func == F_REPLY) begin
        unique case (phase)
          PH_ID_SETTLE, PH_RW_SETTLE, PH_RD_SETTLE: begin
            if (!stat.settle_done) begin
              cmd.inc_settle = 1'b1; nseq[0] = E_RD_ALT; nlen = 3'd1;
            end else if (phase == PH_ID_SETTLE) begin
              nseq[0] = E_WR_ZERO2; nseq[1] = E_WR_ZERO3; nseq[2] = E_WR_ZERO4;
              nseq[3] = E_WR_ZERO5; nseq[4] = E_WR_IDCMD; nseq[5] = E_RD_STATUS;
              nlen = 3'd6; phase_next = PH_ID_FIRST;
            end else if (phase == PH_RW_SETTLE) begin
              cmd.clr_poll = 1'b1;
              nseq[0] = E_WR_CNT; nseq[1] = E_WR_L0; nseq[2] = E_WR_L1;
              nseq[3] = E_WR_L2; nseq[4] = E_WR_RWCMD;
              if (stat.budget_zero) begin nlen = 3'd5; ndone = 1'b1; nst = ST_TIMEOUT; end
              else begin nseq[5] = E_RD_STATUS; nlen = 3'd6; phase_next = PH_RW_DRQ; end
            end else begin
              ndone = 1'b1; nst = ST_OK;
            end
          end
          PH_ID_FIRST: begin
            cmd.clr_poll = 1'b1;
            if (b == 8'h00 || b == 8'hFF) begin ndone = 1'b1; nst = ST_NODEV; end
            else if (stat.budget_zero) begin ndone = 1'b1; nst = ST_TIMEOUT; end
            else begin nseq[0] = E_RD_STATUS; nlen = 3'd1; phase_next = PH_ID_NB; end
          end
          PH_ID_MID, PH_ID_HI: begin
            if (b != 0) begin ndone = 1'b1; nst = ST_NOTATA; end
            else if (phase == PH_ID_MID) begin
              nseq[0] = E_RD_HI; nlen = 3'd1; phase_next = PH_ID_HI;
            end else begin
              cmd.clr_poll = 1'b1;
              if (stat.budget_zero) begin ndone = 1'b1; nst = ST_TIMEOUT; end
              else begin nseq[0] = E_RD_STATUS; nlen = 3'd1; phase_next = PH_ID_DRQ; end
            end
          end
          PH_ID_NB, PH_ID_DRQ, PH_RW_NB, PH_RW_DRQ, PH_WR_FLUSH: begin
            cmd.inc_poll = 1'b1;
            if (pfail_dev) begin ndone = 1'b1; nst = ST_DEVERR; end
            else if (pfail_to) begin ndone = 1'b1; nst = ST_TIMEOUT; end
            else if (pstill) begin nseq[0] = E_RD_STATUS; nlen = 3'd1; end
            else begin
              unique case (phase)
                PH_ID_NB: begin nseq[0] = E_RD_MID; nlen = 3'd1; phase_next = PH_ID_MID; end
                PH_ID_DRQ: begin
                  cmd.clr_index = 1'b1;
                  nseq[0] = E_RD_DATA; nlen = 3'd1; phase_next = PH_ID_DATA;
                end
                PH_RW_NB: begin
                  cmd.clr_settle = 1'b1;
                  nseq[0] = E_WR_DEVSEL; nseq[1] = E_RD_ALT; nlen = 3'd2;
                  phase_next = PH_RW_SETTLE;
                end
                PH_RW_DRQ: begin
                  cmd.clr_index = 1'b1;
                  if (op_is_write) begin ntail = T_NEED_WR; phase_next = PH_WR_DATA; end
                  else begin nseq[0] = E_RD_DATA; nlen = 3'd1; phase_next = PH_RD_DATA; end
                end
                default: begin ndone = 1'b1; nst = ST_OK; end
              endcase
            end
          end
          PH_ID_DATA: begin
            cmd.store_word = 1'b1; cmd.inc_index = 1'b1;
            if (!stat.index_last) begin nseq[0] = E_RD_DATA; nlen = 3'd1; end
            else begin
              cmd.scan_start = 1'b1; cmd.out_clr = 1'b1;
              ntail = T_MODEL; ndone = 1'b1; nst = ST_OK;
            end
          end
          PH_RD_DATA: begin
            npass = 1'b1; npass_sector = 1'b1; cmd.inc_index = 1'b1;
            if (!stat.index_last) begin nseq[0] = E_RD_DATA; nlen = 3'd1; end
            else begin
              cmd.clr_settle = 1'b1; nseq[0] = E_RD_ALT; nlen = 3'd1;
              phase_next = PH_RD_SETTLE;
            end
          end
          default: begin nfire = 1'b0; phase_next = PH_IDLE; end
        endcase
      end else nfire = 1'b0;
      if (ndone) phase_next = PH_IDLE;
    end
    // trim scan and model output run while emitting
    if (run == PH_MODEL_SCAN && !stat.scan_done && stat.scan_busy_space)
      cmd.scan_step = 1'b1;
    if (run == PH_MODEL_OUT && res_valid && !res_stall) begin
      cmd.out_step = 1'b1;
      if (stat.out_last) cmd.set_present = 1'b1;
    end
  end

  // items emitted for the current sequence, in order:
  // pass word, then seq entries, then tail, then done
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      run   <= PH_IDLE;
      seq_len <= '0; seq_pos <= '0;
      tail <= T_NONE; done_flag <= 1'b0; done_st <= ST_OK;
      pass_word_valid <= 1'b0; pass_sector <= 1'b0;
      flush_pending <= 1'b0;
    end else begin
      phase <= phase_next;
      if (nfire) begin
        for (int i = 0; i < 7; i++) seq[i] <= nseq[i];
        seq_len <= nlen; seq_pos <= '0;
        tail <= ntail; done_flag <= ndone; done_st <= nst;
        pass_word_valid <= npass; pass_sector <= npass_sector;
        pass_word <= data;
        flush_pending <= (phase == PH_WR_DATA);
        if (npass || nlen != 0 || ntail != T_NONE || ndone) run <= PH_SEQ;
      end else if (run == PH_SEQ && res_valid && !res_stall) begin
        if (pass_word_valid) pass_word_valid <= 1'b0;
        else if (seq_pos != seq_len) seq_pos <= seq_pos + 3'd1;
        else if (tail == T_NEED_WR) tail <= T_NONE;
        else if (done_flag) done_flag <= 1'b0;
        if (res.last) run <= PH_IDLE;
      end else if (run == PH_SEQ && tail == T_MODEL && !pass_word_valid &&
                   seq_pos == seq_len) begin
        run <= PH_MODEL_SCAN;
      end else if (run == PH_MODEL_SCAN) begin
        if (stat.scan_done || !stat.scan_busy_space) run <= PH_MODEL_OUT;
      end else if (run == PH_MODEL_OUT && res_valid && !res_stall) begin
        if (stat.out_last) begin tail <= T_NONE; run <= PH_SEQ; end
      end
    end
  end

  // result output
  always_comb begin
    ecode_t e;
    logic   more;
    e = seq[seq_pos];
    more = 1'b0;
    res = '0;
    res_valid = 1'b0;
    if (run == PH_MODEL_OUT) begin
      res_valid = 1'b1;
      res.kind = K_MODEL;
      res.word = model_word;
    end else if (run == PH_SEQ) begin
      if (pass_word_valid) begin
        res_valid = 1'b1;
        if (pass_sector) res.kind = K_SECTOR;
        else begin res.kind = K_BUS_WR; res.wide = 1'b1; end
        res.word = pass_word;
        more = (seq_len != 0) || tail != T_NONE || done_flag;
      end else if (seq_pos != seq_len) begin
        res_valid = 1'b1;
        unique case (e)
          E_WR_DEVSEL: begin
            res.reg_offset = 3'd6;
            res.word = (phase == PH_ID_SETTLE) ? 16'h00A0
                                               : {8'h00, 4'hE, latched_lba[27:24]};
          end
          E_WR_ZERO2: res.reg_offset = 3'd2;
          E_WR_ZERO3: res.reg_offset = 3'd3;
          E_WR_ZERO4: res.reg_offset = 3'd4;
          E_WR_ZERO5: res.reg_offset = 3'd5;
          E_WR_IDCMD: begin res.reg_offset = 3'd7; res.word = 16'h00EC; end
          E_WR_CNT:   begin res.reg_offset = 3'd2; res.word = 16'h0001; end
          E_WR_L0:    begin res.reg_offset = 3'd3; res.word = {8'h00, latched_lba[7:0]}; end
          E_WR_L1:    begin res.reg_offset = 3'd4; res.word = {8'h00, latched_lba[15:8]}; end
          E_WR_L2:    begin res.reg_offset = 3'd5; res.word = {8'h00, latched_lba[23:16]}; end
          E_WR_RWCMD: begin
            res.reg_offset = 3'd7;
            res.word = flush_pending ? 16'h00E7 : (op_is_write ? 16'h0030 : 16'h0020);
          end
          E_RD_STATUS: begin res.kind = K_BUS_RD; res.reg_offset = 3'd7; end
          E_RD_ALT:    begin res.kind = K_BUS_RD; res.control_block = 1'b1; end
          E_RD_MID:    begin res.kind = K_BUS_RD; res.reg_offset = 3'd4; end
          E_RD_HI:     begin res.kind = K_BUS_RD; res.reg_offset = 3'd5; end
          E_RD_DATA:   begin res.kind = K_BUS_RD; res.wide = 1'b1; end
          default: ;
        endcase
        more = (seq_pos + 3'd1 != seq_len) || tail != T_NONE || done_flag;
      end else if (tail == T_NEED_WR) begin
        res_valid = 1'b1; res.kind = K_NEED_WR; more = done_flag;
      end else if (tail == T_NONE && done_flag) begin
        res_valid = 1'b1; res.kind = K_DONE; res.status = done_st;
        res.sector_count = total_sectors; more = 1'b0;
      end else more = 1'b1;
      res.last = res_valid && !more;
    end
  end
endmodule

@@ src/ata_pio_host_sequencer.sv @@
// ----------------------------------------------------------------------------
// ata_pio_host_sequencer
// ATA PIO LBA28 host sequencer for the primary master drive.
// ----------------------------------------------------------------------------
// Each input transaction (request, bus read reply or client word) yields its
// result transactions one per cycle while out_stall is low (the trim scan
// pauses them), the last marked by last; the input is stalled until the final
// result is taken. Identify completion trims trailing spaces (up to 40) from
// the model string before the 20 model words and done. poll_budget is at
// address 0.
module ata_pio_host_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [47:0] lba,
  input  logic [15:0] data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic        control_block,
  output logic [2:0]  reg_offset,
  output logic        wide,
  output logic [15:0] word,
  output logic [2:0]  status,
  output logic [31:0] sector_count,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ata_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  result_t     res;
  logic [19:0] poll_budget;
  logic [27:0] latched_lba;
  logic        op_is_write;
  logic [31:0] total_sectors;
  logic [15:0] model_word;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) poll_budget <= POLL_BUDGET_RESET;
    else if (psel && penable && pwrite && paddr == 2'd0) poll_budget <= pwdata[19:0];
  end
  assign prdata = (paddr == 2'd0) ? {12'd0, poll_budget} : 32'd0;

  ata_datapath u_dp (
    .clk, .rst, .cmd, .lba, .data, .poll_budget, .stat,
    .latched_lba, .op_is_write, .total_sectors, .model_word
  );

  ata_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .func, .data, .stat, .latched_lba,
    .op_is_write, .total_sectors, .model_word, .cmd,
    .res_valid(out_valid), .res_stall(out_stall), .res
  );

  assign kind          = res.kind;
  assign control_block = res.control_block;
  assign reg_offset    = res.reg_offset;
  assign wide          = res.wide;
  assign word          = res.word;
  assign status        = res.status;
  assign sector_count  = res.sector_count;
  assign last          = res.last;
endmodule

@@ src/ata_checker.sv @@
// ----------------------------------------------------------------------------
// ata_checker
// Port-level checks for the ATA PIO host sequencer.
// ----------------------------------------------------------------------------
module ata_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] kind,
  input logic       last
);
  import ata_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  // done is always the final result
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_DONE |-> last) else $error("done not last");
  // input is held off while results are pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open with results pending");
  // after the last result is taken, input reopens
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !in_stall) else $error("input not reopened");
endmodule

bind ata_pio_host_sequencer ata_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .kind, .last
);
